[hdl/rotation_matrix_to_quaternion_macros.svh]
// Assertion macros for the rotation matrix to quaternion converter.
// Users must have clk and rst_n in scope at the point of use.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RMQ_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies; used by all modules and by the testbench.
package rmq_pkg;

    localparam int QONE       = 16384;
    localparam int SQ_STEPS   = 18;   // root bits, two radicand bits per step
    localparam int RAD_W      = 36;   // radicand a << 18, padded to even width
    localparam int DIV_STEPS  = 33;   // dividend bits, one quotient bit per step
    localparam int MIN_ROOT   = 512;  // root of the smallest positive argument

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Sideband carried through the square-root pipeline
    typedef struct packed {
        branch_t            branch;
        logic               deg;
        logic signed [17:0] n0;
        logic signed [17:0] n1;
        logic signed [17:0] n2;
    } side_t;

    // Sideband carried through the divider pipeline
    typedef struct packed {
        branch_t     branch;
        logic        deg;
        logic [15:0] quarter;
        logic [2:0]  neg;
    } div_side_t;

endpackage

[hdl/rmq_mat_if.sv]
// Input channel: one rotation matrix per transaction, signed Q2.14 entries.
// Depends on nothing.
interface rmq_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

[hdl/rmq_quat_if.sv]
// Output channel: one quaternion per transaction, signed Q2.14 components.
// Depends on nothing.
interface rmq_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               degenerate;

    modport source (output valid, qx, qy, qz, qw, degenerate, input ready);
    modport sink   (input valid, qx, qy, qz, qw, degenerate, output ready);
endinterface

[hdl/rmq_sqrt.sv]
// Pipelined integer square root, floor(sqrt(rad << 18)), one root bit per stage.
// Depends on rmq_pkg; carries an rmq_pkg::side_t alongside each transaction.
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [16:0] rad,
    input  side_t       in_side,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [17:0] root,
    output side_t       out_side
);

    logic              vld_reg  [SQ_STEPS];
    logic              stg_rdy  [SQ_STEPS];
    logic [17:0]       rem_reg  [SQ_STEPS];
    logic [17:0]       root_reg [SQ_STEPS];
    logic [RAD_W-1:0]  rad_reg  [SQ_STEPS];
    side_t             side_reg [SQ_STEPS];

    logic              vld_src  [SQ_STEPS];
    logic [17:0]       rem_next [SQ_STEPS];
    logic [17:0]       root_next[SQ_STEPS];
    logic [RAD_W-1:0]  rad_next [SQ_STEPS];
    side_t             side_next[SQ_STEPS];

    // Ready ripples back from the output through empty stages
    always_comb
    begin
        for (int i = SQ_STEPS - 1; i >= 0; i--)
        begin
            if (i == SQ_STEPS - 1)
                stg_rdy[i] = !vld_reg[i] || out_ready;
            else
                stg_rdy[i] = !vld_reg[i] || stg_rdy[i + 1];
        end
    end

    // One restoring root step per stage
    always_comb
    begin
        logic [17:0]      rem_in;
        logic [17:0]      root_in;
        logic [RAD_W-1:0] rad_in;
        logic [19:0]      shifted;
        logic [19:0]      trial;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            if (i == 0)
            begin
                vld_src[i]   = in_valid;
                rem_in       = '0;
                root_in      = '0;
                rad_in       = {1'b0, rad, 18'd0};
                side_next[i] = in_side;
            end
            else
            begin
                vld_src[i]   = vld_reg[i - 1];
                rem_in       = rem_reg[i - 1];
                root_in      = root_reg[i - 1];
                rad_in       = rad_reg[i - 1];
                side_next[i] = side_reg[i - 1];
            end
            shifted = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial   = {1'b0, root_in[16:0], 2'b01};
            if (shifted >= trial)
            begin
                rem_next[i]  = 18'(shifted - trial);
                root_next[i] = {root_in[16:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = shifted[17:0];
                root_next[i] = {root_in[16:0], 1'b0};
            end
            rad_next[i] = {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    // Advance each stage when the stage ahead can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_STEPS; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                if (stg_rdy[i])
                    vld_reg[i] <= vld_src[i];
                if (stg_rdy[i] && vld_src[i])
                begin
                    rem_reg[i]  <= rem_next[i];
                    root_reg[i] <= root_next[i];
                    rad_reg[i]  <= rad_next[i];
                    side_reg[i] <= side_next[i];
                end
            end
        end
    end

    assign in_ready  = stg_rdy[0];
    assign out_valid = vld_reg[SQ_STEPS - 1];
    assign root      = root_reg[SQ_STEPS - 1];
    assign out_side  = side_reg[SQ_STEPS - 1];

endmodule

[hdl/rmq_div.sv]
// Pipelined three-lane restoring divider with a shared divisor, one bit per stage.
// Depends on rmq_pkg; carries an rmq_pkg::div_side_t alongside each transaction.
module rmq_div
    import rmq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0][DIV_STEPS-1:0]  dividend,
    input  logic [17:0]                divisor,
    input  div_side_t                  in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0][DIV_STEPS-1:0]  quotient,
    output div_side_t                  out_side
);

    logic                      vld_reg  [DIV_STEPS];
    logic                      stg_rdy  [DIV_STEPS];
    logic [2:0][17:0]          rem_reg  [DIV_STEPS];
    logic [2:0][DIV_STEPS-1:0] num_reg  [DIV_STEPS];
    logic [17:0]               dvs_reg  [DIV_STEPS];
    div_side_t                 side_reg [DIV_STEPS];

    logic                      vld_src  [DIV_STEPS];
    logic [2:0][17:0]          rem_next [DIV_STEPS];
    logic [2:0][DIV_STEPS-1:0] num_next [DIV_STEPS];
    logic [17:0]               dvs_next [DIV_STEPS];
    div_side_t                 side_next[DIV_STEPS];

    // Ready ripples back from the output through empty stages
    always_comb
    begin
        for (int i = DIV_STEPS - 1; i >= 0; i--)
        begin
            if (i == DIV_STEPS - 1)
                stg_rdy[i] = !vld_reg[i] || out_ready;
            else
                stg_rdy[i] = !vld_reg[i] || stg_rdy[i + 1];
        end
    end

    // Shift in one dividend bit per lane, subtract when it fits
    always_comb
    begin
        logic [2:0][17:0]          rem_in;
        logic [2:0][DIV_STEPS-1:0] num_in;
        logic [18:0]               part;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                vld_src[i]   = in_valid;
                rem_in       = '0;
                num_in       = dividend;
                dvs_next[i]  = divisor;
                side_next[i] = in_side;
            end
            else
            begin
                vld_src[i]   = vld_reg[i - 1];
                rem_in       = rem_reg[i - 1];
                num_in       = num_reg[i - 1];
                dvs_next[i]  = dvs_reg[i - 1];
                side_next[i] = side_reg[i - 1];
            end
            for (int k = 0; k < 3; k++)
            begin
                part = {rem_in[k], num_in[k][DIV_STEPS-1]};
                if (part >= {1'b0, dvs_next[i]})
                begin
                    rem_next[i][k] = 18'(part - {1'b0, dvs_next[i]});
                    num_next[i][k] = {num_in[k][DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i][k] = part[17:0];
                    num_next[i][k] = {num_in[k][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // Advance each stage when the stage ahead can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                if (stg_rdy[i])
                    vld_reg[i] <= vld_src[i];
                if (stg_rdy[i] && vld_src[i])
                begin
                    rem_reg[i]  <= rem_next[i];
                    num_reg[i]  <= num_next[i];
                    dvs_reg[i]  <= dvs_next[i];
                    side_reg[i] <= side_next[i];
                end
            end
        end
    end

    assign in_ready  = stg_rdy[0];
    assign out_valid = vld_reg[DIV_STEPS - 1];
    assign quotient  = num_reg[DIV_STEPS - 1];
    assign out_side  = side_reg[DIV_STEPS - 1];

endmodule

[hdl/rotation_matrix_to_quaternion.sv]
// Depth: stage 0, 18-stage root, middle stage, 33-stage divider, output register.
// Throughput: one matrix per cycle while the sink stays ready.
// Stalls hold every stage; empty stages still fill, so bubbles are squeezed out.
// Reset (rst_n low, asynchronous) clears all valid bits; payload is not reset.
// Depends on rmq_pkg, rmq_mat_if, rmq_quat_if, rmq_sqrt, rmq_div and the macro header.
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rmq_mat_if.sink     mat,
    rmq_quat_if.source  quat
);

    // Stage 0: branch, root argument and numerators
    logic signed [18:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [18:0] trace;
    logic signed [18:0] arg;
    side_t              side_next;
    logic [16:0]        rad_next;

    logic        prep_vld_reg;
    side_t       prep_side_reg;
    logic [16:0] prep_rad_reg;
    logic        prep_rdy;

    logic        sqrt_in_ready;
    logic        sqrt_out_valid;
    logic [17:0] sqrt_root;
    side_t       sqrt_side;
    logic        mid_rdy;

    always_comb
    begin
        e00 = 19'(mat.m00);
        e01 = 19'(mat.m01);
        e02 = 19'(mat.m02);
        e10 = 19'(mat.m10);
        e11 = 19'(mat.m11);
        e12 = 19'(mat.m12);
        e20 = 19'(mat.m20);
        e21 = 19'(mat.m21);
        e22 = 19'(mat.m22);
        trace = e00 + e11 + e22;
        if (trace > 0)
        begin
            side_next.branch = BR_TRACE;
            arg          = trace + 19'(QONE);
            side_next.n0 = 18'(e21 - e12);
            side_next.n1 = 18'(e02 - e20);
            side_next.n2 = 18'(e10 - e01);
        end
        else if (e00 > e11 && e00 > e22)
        begin
            side_next.branch = BR_X;
            arg          = 19'(QONE) + e00 - e11 - e22;
            side_next.n0 = 18'(e21 - e12);
            side_next.n1 = 18'(e01 + e10);
            side_next.n2 = 18'(e02 + e20);
        end
        else if (e11 > e22)
        begin
            side_next.branch = BR_Y;
            arg          = 19'(QONE) + e11 - e00 - e22;
            side_next.n0 = 18'(e02 - e20);
            side_next.n1 = 18'(e01 + e10);
            side_next.n2 = 18'(e12 + e21);
        end
        else
        begin
            side_next.branch = BR_Z;
            arg          = 19'(QONE) + e22 - e00 - e11;
            side_next.n0 = 18'(e10 - e01);
            side_next.n1 = 18'(e02 + e20);
            side_next.n2 = 18'(e12 + e21);
        end
        side_next.deg = arg[18] || (arg == '0);
        rad_next      = side_next.deg ? '0 : arg[16:0];
    end

    assign prep_rdy  = !prep_vld_reg || sqrt_in_ready;
    assign mat.ready = prep_rdy;

    // Hold stage 0 until the root pipeline takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_vld_reg <= 1'b0;
        else if (prep_rdy)
        begin
            prep_vld_reg <= mat.valid;
            if (mat.valid)
            begin
                prep_side_reg <= side_next;
                prep_rad_reg  <= rad_next;
            end
        end
    end

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_vld_reg),
        .in_ready  (sqrt_in_ready),
        .rad       (prep_rad_reg),
        .in_side   (prep_side_reg),
        .out_valid (sqrt_out_valid),
        .out_ready (mid_rdy),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    // Middle stage: S/4 and rounded dividends
    logic                      mid_vld_reg;
    logic [2:0][DIV_STEPS-1:0] mid_num_reg;
    logic [17:0]               mid_dvs_reg;
    div_side_t                 mid_side_reg;
    logic [2:0][DIV_STEPS-1:0] num_next;
    div_side_t                 dside_next;
    logic                      div_in_ready;

    always_comb
    begin
        logic signed [17:0] n [3];
        logic [17:0]        mag;
        n[0] = sqrt_side.n0;
        n[1] = sqrt_side.n1;
        n[2] = sqrt_side.n2;
        for (int k = 0; k < 3; k++)
        begin
            mag = n[k][17] ? 18'(-n[k]) : 18'(n[k]);
            num_next[k] = DIV_STEPS'({mag[16:0], 15'd0}) + DIV_STEPS'(sqrt_root[17:1]);
            dside_next.neg[k] = n[k][17];
        end
        dside_next.branch  = sqrt_side.branch;
        dside_next.deg     = sqrt_side.deg;
        dside_next.quarter = 16'((19'(sqrt_root) + 19'd4) >> 3);
    end

    assign mid_rdy = !mid_vld_reg || div_in_ready;

    // Hold the middle stage until the divider takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_vld_reg <= 1'b0;
        else if (mid_rdy)
        begin
            mid_vld_reg <= sqrt_out_valid;
            if (sqrt_out_valid)
            begin
                mid_num_reg  <= num_next;
                mid_dvs_reg  <= sqrt_root;
                mid_side_reg <= dside_next;
            end
        end
    end

    logic                      div_out_valid;
    logic [2:0][DIV_STEPS-1:0] div_quot;
    div_side_t                 div_side;
    logic                      out_rdy;

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_vld_reg),
        .in_ready  (div_in_ready),
        .dividend  (mid_num_reg),
        .divisor   (mid_dvs_reg),
        .in_side   (mid_side_reg),
        .out_valid (div_out_valid),
        .out_ready (out_rdy),
        .quotient  (div_quot),
        .out_side  (div_side)
    );

    // Output stage: saturate, apply sign, route to components, zero degenerate results
    logic        out_vld_reg;
    logic [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic        deg_reg;
    logic [2:0][15:0] dq;
    logic [15:0] qx_next, qy_next, qz_next, qw_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (div_side.neg[k])
                dq[k] = (div_quot[k] > DIV_STEPS'(32768)) ? 16'h8000
                                                          : 16'(-div_quot[k]);
            else
                dq[k] = (div_quot[k] > DIV_STEPS'(32767)) ? 16'h7fff
                                                          : div_quot[k][15:0];
        end
        case (div_side.branch)
            BR_TRACE:
            begin
                qw_next = div_side.quarter;
                qx_next = dq[0];
                qy_next = dq[1];
                qz_next = dq[2];
            end
            BR_X:
            begin
                qw_next = dq[0];
                qx_next = div_side.quarter;
                qy_next = dq[1];
                qz_next = dq[2];
            end
            BR_Y:
            begin
                qw_next = dq[0];
                qx_next = dq[1];
                qy_next = div_side.quarter;
                qz_next = dq[2];
            end
            default:
            begin
                qw_next = dq[0];
                qx_next = dq[1];
                qy_next = dq[2];
                qz_next = div_side.quarter;
            end
        endcase
        if (div_side.deg)
        begin
            qw_next = '0;
            qx_next = '0;
            qy_next = '0;
            qz_next = '0;
        end
    end

    assign out_rdy = !out_vld_reg || quat.ready;

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_rdy)
        begin
            out_vld_reg <= div_out_valid;
            if (div_out_valid)
            begin
                qx_reg  <= qx_next;
                qy_reg  <= qy_next;
                qz_reg  <= qz_next;
                qw_reg  <= qw_next;
                deg_reg <= div_side.deg;
            end
        end
    end

    assign quat.valid      = out_vld_reg;
    assign quat.qx         = qx_reg;
    assign quat.qy         = qy_reg;
    assign quat.qz         = qz_reg;
    assign quat.qw         = qw_reg;
    assign quat.degenerate = deg_reg;

    `RMQ_ASSERT_IMPLIES(a_deg_zero, quat.valid && quat.degenerate,
        quat.qx == 0 && quat.qy == 0 && quat.qz == 0 && quat.qw == 0,
        "degenerate result with nonzero component")
    `RMQ_ASSERT_IMPLIES(a_deg_not_trace, prep_vld_reg && prep_side_reg.deg,
        prep_side_reg.branch != BR_TRACE, "degenerate argument in trace branch")
    `RMQ_ASSERT_IMPLIES(a_root_min, sqrt_out_valid && !sqrt_side.deg,
        sqrt_root >= 18'(MIN_ROOT), "root below smallest positive argument")
    `RMQ_ASSERT_NEXT(a_quarter_nonzero, sqrt_out_valid && mid_rdy && !sqrt_side.deg,
        mid_vld_reg && mid_side_reg.quarter != 0, "zero S/4 for valid argument")

endmodule

[bench/rmq_bench_if.sv]
`timescale 1ns / 1ps
// Bench package: the packed result type that the scoreboard compares.
// Depends on nothing; the bench instantiates the RTL interfaces directly.
package rmq_bench_pkg;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic               degenerate;
    } quat_t;
endpackage

[bench/rotation_matrix_to_quaternion_test.sv]
`timescale 1ns / 1ps
// Testbench for the rotation matrix to quaternion converter: random and directed
// matrices, random idling on both sides, results checked against a built-in predictor.
// Depends on rmq_pkg, rmq_bench_pkg, rmq_mat_if, rmq_quat_if and the RTL.
module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;
    import rmq_bench_pkg::*;

    localparam int LATENCY  = 54;
    localparam int WD_LIMIT = 2000;

    typedef logic signed [15:0] entry_t;

    class quat_scoreboard;
        quat_t pending[$];
        int    mismatches;

        // Integer root by bit pairs
        function automatic longint unsigned root64(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function automatic entry_t clamp16(longint v);
            if (v > 32767)
                return 16'sh7fff;
            if (v < -32768)
                return 16'sh8000;
            return entry_t'(v);
        endfunction

        // Divide by S, magnitude rounded half away from zero
        function automatic entry_t over_s(int d, longint unsigned sq);
            longint unsigned mag;
            longint q;
            mag = (d < 0) ? longint'(-d) : longint'(d);
            q = longint'(((mag << 15) + (sq >> 1)) / sq);
            return clamp16(d < 0 ? -q : q);
        endfunction

        function automatic quat_t convert(entry_t m[9]);
            quat_t r;
            int tr;
            int arg;
            branch_t br;
            longint unsigned sq;
            entry_t quarter;
            r = '0;
            tr = m[0] + m[4] + m[8];
            if (tr > 0)
            begin
                br = BR_TRACE;
                arg = tr + QONE;
            end
            else if (m[0] > m[4] && m[0] > m[8])
            begin
                br = BR_X;
                arg = QONE + m[0] - m[4] - m[8];
            end
            else if (m[4] > m[8])
            begin
                br = BR_Y;
                arg = QONE + m[4] - m[0] - m[8];
            end
            else
            begin
                br = BR_Z;
                arg = QONE + m[8] - m[0] - m[4];
            end
            if (arg <= 0)
            begin
                r.degenerate = 1'b1;
                return r;
            end
            sq = root64(longint'(arg) << 18);
            quarter = clamp16(longint'((sq + 4) >> 3));
            case (br)
                BR_TRACE:
                begin
                    r.qw = quarter;
                    r.qx = over_s(m[7] - m[5], sq);
                    r.qy = over_s(m[2] - m[6], sq);
                    r.qz = over_s(m[3] - m[1], sq);
                end
                BR_X:
                begin
                    r.qw = over_s(m[7] - m[5], sq);
                    r.qx = quarter;
                    r.qy = over_s(m[1] + m[3], sq);
                    r.qz = over_s(m[2] + m[6], sq);
                end
                BR_Y:
                begin
                    r.qw = over_s(m[2] - m[6], sq);
                    r.qx = over_s(m[1] + m[3], sq);
                    r.qy = quarter;
                    r.qz = over_s(m[5] + m[7], sq);
                end
                default:
                begin
                    r.qw = over_s(m[3] - m[1], sq);
                    r.qx = over_s(m[2] + m[6], sq);
                    r.qy = over_s(m[5] + m[7], sq);
                    r.qz = quarter;
                end
            endcase
            return r;
        endfunction

        function void note_matrix(entry_t m[9]);
            pending.push_back(convert(m));
        endfunction

        function void check_quat(quat_t got);
            quat_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quaternion %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"quaternion mismatch: exp x=%0d y=%0d z=%0d w=%0d deg=%0b,",
                              " got x=%0d y=%0d z=%0d w=%0d deg=%0b"},
                        want.qx, want.qy, want.qz, want.qw, want.degenerate,
                        got.qx, got.qy, got.qz, got.qw, got.degenerate);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic sending_done;
    int   idle_cycles;
    quat_scoreboard board;

    rmq_mat_if  mat();
    rmq_quat_if quat();

    rotation_matrix_to_quaternion i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat.sink),
        .quat  (quat.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        mat.valid = 1'b0;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
        quat.ready = 1'b0;
        sending_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Send one matrix, hold until accepted
    task automatic send_matrix(entry_t m[9]);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            mat.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mat.valid <= 1'b1;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22}
            <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        do
            @(posedge clk);
        while (!mat.ready);
        board.note_matrix(m);
    endtask

    function automatic entry_t pick_value();
        case ($urandom_range(0, 5))
            0: return entry_t'($urandom);
            1: return entry_t'($urandom_range(0, 4) * 16384 - 32768);
            2: return entry_t'($urandom_range(0, 32767) - 16384);
            default: return entry_t'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    // Build a near-rotation from a random quaternion in real arithmetic
    task automatic rotation_matrix(output entry_t m[9]);
        real a, b, c, d, n;
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        d = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(a*a + b*b + c*c + d*d) + 1.0e-9;
        a /= n; b /= n; c /= n; d /= n;
        m[0] = entry_t'($rtoi(16384.0 * (1 - 2*(c*c + d*d))));
        m[1] = entry_t'($rtoi(16384.0 * 2*(b*c - d*a)));
        m[2] = entry_t'($rtoi(16384.0 * 2*(b*d + c*a)));
        m[3] = entry_t'($rtoi(16384.0 * 2*(b*c + d*a)));
        m[4] = entry_t'($rtoi(16384.0 * (1 - 2*(b*b + d*d))));
        m[5] = entry_t'($rtoi(16384.0 * 2*(c*d - b*a)));
        m[6] = entry_t'($rtoi(16384.0 * 2*(b*d - c*a)));
        m[7] = entry_t'($rtoi(16384.0 * 2*(c*d + b*a)));
        m[8] = entry_t'($rtoi(16384.0 * (1 - 2*(b*b + c*c))));
    endtask

    // Stimulus
    initial
    begin
        entry_t m[9];
        wait (rst_n === 1'b1);
        @(posedge clk);
        // Identity, trace branch
        m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_matrix(m);
        // Each diagonal branch by half turns
        m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        send_matrix(m);
        // Ties on the diagonal: later branch wins
        m = '{-8192, 100, 200, 300, -8192, 400, 500, 600, -16384};
        send_matrix(m);
        m = '{0, 1, 2, 3, 0, 4, 5, 6, 0};
        send_matrix(m);
        // Non-positive traces with large root arguments
        m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
        send_matrix(m);
        m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 16384};
        send_matrix(m);
        m = '{8192, 0, 0, 0, 8192, 0, 0, 0, -16384};
        send_matrix(m);
        // Saturating components and extreme entries
        m = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
        send_matrix(m);
        m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(m);
        m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 32767};
        send_matrix(m);
        m = '{-16384, 32767, 32767, -32768, -16385, -32768, 32767, 32767, -16385};
        send_matrix(m);
        for (int i = 0; i < 1950; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                rotation_matrix(m);
            else
                foreach (m[k])
                    m[k] = pick_value();
            send_matrix(m);
        end
        mat.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Result side: random stalls, check each accepted transaction
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                quat.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            quat.ready <= 1'b1;
            do
                @(posedge clk);
            while (!quat.valid);
            board.check_quat('{quat.qx, quat.qy, quat.qz, quat.qw, quat.degenerate});
        end
    end

    // Watchdog on cycles with no accepted transaction; end the run when it trips
    always @(posedge clk)
    begin
        if ((mat.valid && mat.ready) || (quat.valid && quat.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Wind down and report
    initial
    begin
        idle_cycles = 0;
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[rotation_matrix_to_quaternion.f]
+incdir+hdl
hdl/rmq_pkg.sv
hdl/rmq_mat_if.sv
hdl/rmq_quat_if.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion.sv
bench/rmq_bench_if.sv
bench/rotation_matrix_to_quaternion_test.sv
